// ----- src/voltage_to_charge_percent_assert.svh -----
// Assertion macros used by the checker file of this block.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef VOLTAGE_TO_CHARGE_PERCENT_ASSERT_SVH
`define VOLTAGE_TO_CHARGE_PERCENT_ASSERT_SVH

// Normal check, switched off while reset is high.
`define VTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that also covers the reset cycles themselves.
`define VTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/vtc_pkg.sv -----
`default_nettype none
package vtc_pkg;

  localparam int CurvePoints = 21;
  localparam int VoltW = 16;
  localparam int MvW = 12;
  localparam int PctW = 7;
  localparam int SegW = 5;
  localparam int OffW = 9;
  localparam int NumW = 12;
  localparam int QuoW = 3;
  localparam int PctSpan = 5;

  typedef logic [MvW-1:0] mv_t;
  typedef logic [PctW-1:0] pct_t;
  typedef logic [SegW-1:0] seg_t;

  // Discharge curve, voltages descending.
  localparam mv_t CURVE_MV [CurvePoints] = '{
    12'd4070, 12'd4005, 12'd3954, 12'd3915, 12'd3838, 12'd3786, 12'd3747,
    12'd3696, 12'd3644, 12'd3618, 12'd3605, 12'd3580, 12'd3554, 12'd3541,
    12'd3515, 12'd3489, 12'd3464, 12'd3438, 12'd3412, 12'd3309, 12'd2870
  };

  localparam pct_t CURVE_PCT [CurvePoints] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65, 7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30, 7'd25, 7'd20, 7'd15, 7'd10, 7'd5, 7'd0
  };

  // Result of the segment search for one voltage.
  typedef struct packed {
    logic clamp_hi;
    logic clamp_lo;
    seg_t seg;
  } seg_info_t;

  // Width of the segment that ends at point seg, in millivolts.
  function automatic mv_t seg_span(seg_t seg);
    mv_t span;
    span = '0;
    if (seg != '0 && int'(seg) < CurvePoints) begin
      span = CURVE_MV[SegW'(seg - 1'b1)] - CURVE_MV[seg];
    end
    return span;
  endfunction

  // Low voltage point of the segment, or zero for an unused code.
  function automatic mv_t seg_base_mv(seg_t seg);
    mv_t mv;
    mv = '0;
    if (int'(seg) < CurvePoints) begin
      mv = CURVE_MV[seg];
    end
    return mv;
  endfunction

  function automatic pct_t seg_base_pct(seg_t seg);
    pct_t p;
    p = '0;
    if (int'(seg) < CurvePoints) begin
      p = CURVE_PCT[seg];
    end
    return p;
  endfunction

  // Quotient step threshold j * span; a constant per segment.
  function automatic logic [NumW-1:0] seg_thr(seg_t seg, logic [QuoW-1:0] j);
    logic [NumW-1:0] span;
    span = NumW'(seg_span(seg));
    return NumW'(span * NumW'(j));
  endfunction

endpackage
`default_nettype wire

// ----- src/vtc_in_if.sv -----
`default_nettype none
interface vtc_in_if;
  import vtc_pkg::*;

  logic valid;
  logic ready;
  logic [VoltW-1:0] cell_mv;

  modport source (output valid, output cell_mv, input ready);
  modport sink (input valid, input cell_mv, output ready);
endinterface
`default_nettype wire

// ----- src/vtc_out_if.sv -----
`default_nettype none
interface vtc_out_if;
  import vtc_pkg::*;

  logic valid;
  logic ready;
  logic [PctW-1:0] charge_percent;

  modport source (output valid, output charge_percent, input ready);
  modport sink (input valid, input charge_percent, output ready);
endinterface
`default_nettype wire

// ----- src/vtc_seg_find.sv -----
`default_nettype none
module vtc_seg_find (
  input  wire logic [vtc_pkg::VoltW-1:0] volt,
  output vtc_pkg::seg_info_t             info
);
  import vtc_pkg::*;

  // All compares run in parallel; the lowest matching point index wins.
  always_comb begin
    info.clamp_hi = (volt >= VoltW'(CURVE_MV[0]));
    info.clamp_lo = (volt <= VoltW'(CURVE_MV[CurvePoints-1]));
    info.seg = SegW'(CurvePoints - 1);
    for (int k = CurvePoints - 1; k >= 1; k--) begin
      if (volt >= VoltW'(CURVE_MV[k])) begin
        info.seg = SegW'(k);
      end
    end
  end
endmodule
`default_nettype wire

// ----- src/voltage_to_charge_percent.sv -----
`default_nettype none
// Cell voltage to state-of-charge converter.
//
// The volt channel carries one request per measured cell voltage in
// millivolts (cell_mv, unsigned 16 bits). The pct channel returns one
// charge_percent (0 to 100) per request, in request order. The value is
// read from a fixed 21-point discharge curve with linear interpolation
// between points, rounded to nearest with halves rounding up. Voltages at
// or above the top point give 100 and at or below the bottom point give 0.
//
// The datapath is a three-stage pipeline: segment search, offset and
// rounded numerator, then quotient and final add into the output register.
// A result reaches the output register after passing the stage 1 and stage 2 registers.
// Throughput is one request per cycle while the receiver takes results; each stage holds one request.
//
// Every stage has its own valid bit and takes a new request when it is
// empty or when the stage after it moves. When the receiver stalls, the
// output register holds its result steady and the pipeline fills behind it;
// ready on the volt channel drops only once all three stages are full.
// Reset clears the valid bits, so the block comes up empty and ready.
module voltage_to_charge_percent (
  input wire logic   clk,
  input wire logic   rst,
  vtc_in_if.sink     volt,
  vtc_out_if.source  pct
);
  import vtc_pkg::*;

  // Stage 1: segment search result and the voltage itself.
  logic              s1_valid;
  logic [VoltW-1:0]  s1_volt;
  seg_info_t         s1_info;
  seg_info_t         seg_info_next;

  // Stage 2: rounded numerator of the interpolation.
  logic              s2_valid;
  seg_t              s2_seg;
  pct_t              s2_base;
  logic [NumW-1:0]   s2_num;

  // Stage 3: output register.
  logic              out_valid;
  pct_t              out_pct;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;

  assign s3_ready = !out_valid || pct.ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign volt.ready = s1_ready;

  vtc_seg_find u_seg_find (
    .volt (volt.cell_mv),
    .info (seg_info_next)
  );

  // Offset into the segment and the numerator pct_span * off + span / 2.
  // The offset is below the widest span, so nine bits hold it. Clamped
  // requests use a zero offset, which makes the quotient zero.
  logic [VoltW-1:0] off_full;
  logic [OffW-1:0]  s2_off_next;
  logic [NumW-1:0]  s2_num_next;
  pct_t             s2_base_next;
  mv_t              s1_span;

  always_comb begin
    s1_span = seg_span(s1_info.seg);
    off_full = s1_volt - VoltW'(seg_base_mv(s1_info.seg));
    if (s1_info.clamp_hi || s1_info.clamp_lo) begin
      s2_off_next = '0;
    end else begin
      s2_off_next = off_full[OffW-1:0];
    end
    s2_num_next = NumW'(s2_off_next) * NumW'(PctSpan) + NumW'(s1_span >> 1);
    if (s1_info.clamp_hi) begin
      s2_base_next = CURVE_PCT[0];
    end else if (s1_info.clamp_lo) begin
      s2_base_next = CURVE_PCT[CurvePoints-1];
    end else begin
      s2_base_next = seg_base_pct(s1_info.seg);
    end
  end

  // The quotient never exceeds the percent span, so it is the count of
  // multiples of the segment width that the numerator reaches.
  logic [QuoW-1:0] quo;

  always_comb begin
    quo = '0;
    for (int j = 1; j <= PctSpan; j++) begin
      if (s2_num >= seg_thr(s2_seg, QuoW'(j))) begin
        quo = quo + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= volt.valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && volt.valid) begin
      s1_volt <= volt.cell_mv;
      s1_info <= seg_info_next;
    end
    if (s2_ready && s1_valid) begin
      s2_seg  <= s1_info.seg;
      s2_base <= s2_base_next;
      s2_num  <= s2_num_next;
    end
    if (s3_ready && s2_valid) begin
      out_pct <= s2_base + PctW'(quo);
    end
  end

  assign pct.valid = out_valid;
  assign pct.charge_percent = out_pct;

endmodule
`default_nettype wire

// ----- src/vtc_checker.sv -----
`default_nettype none
`include "voltage_to_charge_percent_assert.svh"
module vtc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [vtc_pkg::VoltW-1:0]   cell_mv,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [vtc_pkg::PctW-1:0]    charge_percent
);
  import vtc_pkg::*;

  logic in_acc;
  logic top_acc;
  logic out_stall;
  logic full_out;

  assign in_acc    = in_valid && in_ready;
  assign top_acc   = in_acc && (cell_mv >= VoltW'(CURVE_MV[0]));
  assign out_stall = out_valid && !out_ready;
  assign full_out  = out_valid && (charge_percent == PctW'(100));

  // A result waiting on a stalled receiver does not change.
  `VTC_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(charge_percent), "result changed")

  // The block comes out of reset with nothing to deliver.
  `VTC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

  // With the receiver taking results, an accepted request passes stage 1 and stage 2 and is then deliverable.
  `VTC_ASSERT(a_latency, in_acc ##1 out_ready ##1 out_ready |=> out_valid, "result late")

  // A voltage at or above the top curve point yields a full charge.
  `VTC_ASSERT(a_top_clamp, top_acc ##1 out_ready ##1 out_ready |=> full_out, "top not full")

endmodule

bind voltage_to_charge_percent vtc_checker u_vtc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (volt.valid),
  .in_ready       (volt.ready),
  .cell_mv        (volt.cell_mv),
  .out_valid      (pct.valid),
  .out_ready      (pct.ready),
  .charge_percent (pct.charge_percent)
);
`default_nettype wire

// ----- verif/vtc_charge_checker.sv -----
// Watches both channels of the converter, predicts the charge percent of
// every accepted request and compares it with the results in order.
module vtc_charge_checker (
  input wire logic clk,
  input wire logic rst,
  vtc_in_if        volt,
  vtc_out_if       pct,
  output int       mismatches,
  output int       results_due
);
  import vtc_pkg::*;

  localparam int ReportLimit = 10;

  pct_t percent_due_q [$];

  // Linear interpolation on the discharge curve, rounded to nearest.
  function automatic pct_t soc_from_mv(logic [VoltW-1:0] mv);
    int unsigned v;
    int unsigned span_mv;
    int unsigned pct_step;
    int unsigned soc;
    bit          found;
    v = mv;
    soc = 0;
    found = 1'b0;
    if (v >= CURVE_MV[0]) begin
      soc = CURVE_PCT[0];
    end else if (v <= CURVE_MV[CurvePoints-1]) begin
      soc = CURVE_PCT[CurvePoints-1];
    end else begin
      for (int k = 1; k < CurvePoints; k++) begin
        if (!found && v >= CURVE_MV[k]) begin
          found = 1'b1;
          span_mv = CURVE_MV[k-1] - CURVE_MV[k];
          pct_step = CURVE_PCT[k-1] - CURVE_PCT[k];
          soc = CURVE_PCT[k] + (pct_step * (v - CURVE_MV[k]) + span_mv / 2) / span_mv;
        end
      end
    end
    if (soc > 100) begin
      soc = 100;
    end
    return PctW'(soc);
  endfunction

  always @(posedge clk) begin : compare
    pct_t want;
    if (!rst) begin
      if (volt.valid && volt.ready) begin
        percent_due_q.push_back(soc_from_mv(volt.cell_mv));
      end
      if (pct.valid && pct.ready) begin
        if (percent_due_q.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("%0t: result %0d with no request outstanding", $realtime,
                     pct.charge_percent);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = percent_due_q.pop_front();
          if (pct.charge_percent !== want) begin
            if (mismatches < ReportLimit) begin
              $display("%0t: charge_percent expected %0d, got %0d", $realtime, want,
                       pct.charge_percent);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
    end
    results_due <= percent_due_q.size();
  end

endmodule

// ----- verif/voltage_to_charge_percent_tb.sv -----
// Top of the converter testbench. It drives voltage requests, shapes the
// back-pressure on the result channel and gives the verdict; checking is
// done by the checker instance that sits beside the block.
module voltage_to_charge_percent_tb;
  import vtc_pkg::*;

  localparam int TotalItems = 1550;
  // The block holds three requests, so this hold-off is plenty to fill it
  // and stall the volt channel.
  localparam int LongHoldCycles = 60;
  // Three pipeline stages; a little margin on top for the final drain.
  localparam int DrainCycles = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int sent_count = 0;
  int holds_asked = 0;
  int mismatches;
  int results_due;

  vtc_in_if  volt_ch ();
  vtc_out_if pct_ch ();

  always #5 clk = ~clk;

  voltage_to_charge_percent u_dut (
    .clk  (clk),
    .rst  (rst),
    .volt (volt_ch),
    .pct  (pct_ch)
  );

  vtc_charge_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .volt        (volt_ch),
    .pct         (pct_ch),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // Offer one request and stay until it is accepted. Valid is left high so
  // that a following request goes out back to back; the caller lowers it
  // only when a gap follows.
  task automatic send_voltage(input logic [VoltW-1:0] mv);
    volt_ch.valid <= 1'b1;
    volt_ch.cell_mv <= mv;
    @(posedge clk);
    while (!volt_ch.ready) begin
      @(posedge clk);
    end
    sent_count++;
  endtask

  // With the volt channel idle, wait until every expected result has come back.
  // The count seen here is registered in the checker, so wait for the next
  // edge first to include the request accepted last.
  task automatic wait_drained();
    @(posedge clk);
    while (results_due != 0) begin
      @(posedge clk);
    end
  endtask

  // Random voltage. Half the values fall on the curve itself, where the
  // interpolation happens; some sit on or next to a curve point, some are
  // taken over the whole 16-bit range so that every input bit toggles, and
  // the rest crowd the two clamp regions.
  function automatic logic [VoltW-1:0] next_voltage();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 50) begin
      v = $urandom_range(4080, 2860);
    end else if (sel < 65) begin
      v = int'(CURVE_MV[$urandom_range(CurvePoints-1)]) + $urandom_range(2) - 1;
    end else if (sel < 85) begin
      v = $urandom_range(16'hFFFF);
    end else if (sel < 92) begin
      v = $urandom_range(64);
    end else begin
      v = $urandom_range(4110, 4040);
    end
    return VoltW'(v);
  endfunction

  // Result channel back-pressure. The receiver runs through stretches of
  // random length, each one always ready, ready at random, or mostly
  // stalled. When the stimulus asks for a long hold-off it drops ready and
  // counts out the hold-off here, while the sender keeps offering.
  initial begin : rx_pattern
    int holds_done;
    int mode;
    int stretch;
    holds_done = 0;
    mode = 0;
    stretch = 0;
    pct_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_asked != holds_done) begin
        pct_ch.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk);
        holds_done++;
      end
      if (stretch == 0) begin
        mode = $urandom_range(2);
        stretch = $urandom_range(40, 4);
      end
      stretch--;
      case (mode)
        0: begin
          pct_ch.ready <= 1'b1;
        end
        1: begin
          pct_ch.ready <= 1'($urandom_range(1));
        end
        default: begin
          pct_ch.ready <= ($urandom_range(3) == 0);
        end
      endcase
    end
  end

  // Stimulus: reset, a directed set of voltages, a long receiver hold-off
  // with the sender pushing, then random bursts with random gaps.
  initial begin : stimulus
    logic [VoltW-1:0] directed_mv [$];
    int burst;
    int gap;
    volt_ch.valid = 1'b0;
    volt_ch.cell_mv = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The extremes of the field and both clamp points with their neighbors,
    // a few inner points where the result must be exactly the point's
    // percent, and 3631, where the rounding term sits exactly on a half and
    // must round up. Bit 15 alone still clamps to full charge.
    directed_mv = '{16'd0, 16'd1, 16'd2869, 16'd2870, 16'd2871, 16'd3309, 16'd3412,
                    16'd3630, 16'd3631, 16'd3541, 16'd3605, 16'd3747, 16'd3954,
                    16'd4005, 16'd4069, 16'd4070, 16'd4071, 16'd32767, 16'd32768,
                    16'd65535};
    foreach (directed_mv[i]) begin
      send_voltage(directed_mv[i]);
    end
    volt_ch.valid <= 1'b0;
    wait_drained();

    // Long hold-off on the result side while requests keep coming, so the
    // pipeline fills and ready on the volt channel has to drop.
    holds_asked++;
    repeat (20) send_voltage(next_voltage());
    volt_ch.valid <= 1'b0;
    wait_drained();

    while (sent_count < TotalItems) begin
      burst = $urandom_range(24, 1);
      for (int i = 0; i < burst && sent_count < TotalItems; i++) begin
        send_voltage(next_voltage());
      end
      // Now and then let the block run completely dry before going on.
      if ($urandom_range(15) == 0) begin
        volt_ch.valid <= 1'b0;
        wait_drained();
      end else begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
        if (gap != 0) begin
          volt_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    volt_ch.valid <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- voltage_to_charge_percent.f -----
+incdir+src
src/vtc_pkg.sv
src/vtc_in_if.sv
src/vtc_out_if.sv
src/vtc_seg_find.sv
src/voltage_to_charge_percent.sv
src/vtc_checker.sv
verif/vtc_charge_checker.sv
verif/voltage_to_charge_percent_tb.sv
